// ===== design/qta_pkg.sv =====
// Package for the quadrature threshold adjuster.
// Holds the request and result payload types, the decoder struct and the shared codes.
// No dependencies.
package qta_pkg;

    localparam logic KIND_ENCODER = 1'b0;
    localparam logic KIND_BUTTON  = 1'b1;

    localparam logic [1:0] QUAD_S0 = 2'd0;
    localparam logic [1:0] QUAD_S1 = 2'd1;
    localparam logic [1:0] QUAD_S2 = 2'd2;
    localparam logic [1:0] QUAD_S3 = 2'd3;

    localparam logic [7:0] STEP_UP   = 8'h01;
    localparam logic [7:0] STEP_DOWN = 8'hFF;

    typedef struct packed {
        logic kind;
        logic enc_a;
        logic enc_b;
        logic low_button_n;
        logic high_button_n;
        logic servo_active;
    } qta_in_t;

    typedef struct packed {
        logic [7:0] low_threshold;
        logic [7:0] high_threshold;
        logic       select_high;
        logic       encoder_moved;
        logic       buttons_seen;
        logic       servo_update;
        logic [7:0] servo_value;
    } qta_out_t;

    // Quadrature decoder verdict passed to the core.
    typedef struct packed {
        logic       moved;
        logic       up;
        logic [1:0] next_state;
    } qta_quad_t;

endpackage

// ===== design/qta_quad.sv =====
// Quadrature decoder: next state and step direction from current state and A/B levels.
// Depends on qta_pkg.
module qta_quad (
    input  logic [1:0]        state,
    input  logic              enc_a,
    input  logic              enc_b,
    output qta_pkg::qta_quad_t quad
);
    import qta_pkg::*;

    logic [1:0] nxt;
    logic       up;

    // B test comes after A test, so B wins when both pins moved.
    always_comb begin
        nxt = state;
        up  = 1'b0;
        case (state)
            QUAD_S0: begin
                if (enc_a) begin nxt = QUAD_S1; up = 1'b0; end
                if (enc_b) begin nxt = QUAD_S2; up = 1'b1; end
            end
            QUAD_S1: begin
                if (!enc_a) begin nxt = QUAD_S0; up = 1'b1; end
                if (enc_b)  begin nxt = QUAD_S3; up = 1'b0; end
            end
            QUAD_S2: begin
                if (enc_a)  begin nxt = QUAD_S3; up = 1'b1; end
                if (!enc_b) begin nxt = QUAD_S0; up = 1'b0; end
            end
            default: begin
                if (!enc_a) begin nxt = QUAD_S2; up = 1'b0; end
                if (!enc_b) begin nxt = QUAD_S1; up = 1'b1; end
            end
        endcase
    end

    assign quad.moved      = (nxt != state);
    assign quad.up         = up;
    assign quad.next_state = nxt;

endmodule

// ===== design/qta_core.sv =====
// Threshold state, event handling and result register.
// Depends on qta_pkg and qta_quad.
module qta_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  qta_pkg::qta_in_t  req,
    output qta_pkg::qta_out_t result
);
    import qta_pkg::*;

    logic [1:0] quad_state_reg, quad_state_next;
    logic [7:0] low_value_reg, low_value_next;
    logic [7:0] high_value_reg, high_value_next;
    logic       high_sel_reg, high_sel_next;
    qta_out_t   result_reg, result_next;

    qta_quad_t  quad;
    logic [7:0] step;
    logic [7:0] sel_value;
    logic [7:0] sel_stepped;

    qta_quad u_quad (
        .state (quad_state_reg),
        .enc_a (req.enc_a),
        .enc_b (req.enc_b),
        .quad  (quad)
    );

    assign step        = quad.up ? STEP_UP : STEP_DOWN;
    assign sel_value   = high_sel_reg ? high_value_reg : low_value_reg;
    assign sel_stepped = sel_value + step;

    always_comb begin
        quad_state_next = quad_state_reg;
        low_value_next  = low_value_reg;
        high_value_next = high_value_reg;
        high_sel_next   = high_sel_reg;
        result_next     = '0;
        case (req.kind)
            KIND_ENCODER: begin
                if (quad.moved) begin
                    quad_state_next = quad.next_state;
                    if (high_sel_reg) high_value_next = sel_stepped;
                    else              low_value_next  = sel_stepped;
                    result_next.encoder_moved = 1'b1;
                    if (req.servo_active) begin
                        result_next.servo_update = 1'b1;
                        result_next.servo_value  = sel_stepped;
                    end
                end
            end
            default: begin
                result_next.buttons_seen = 1'b1;
                if (!req.high_button_n) begin
                    high_sel_next            = 1'b1;
                    result_next.servo_update = 1'b1;
                    result_next.servo_value  = high_value_reg;
                end else if (!req.low_button_n) begin
                    high_sel_next            = 1'b0;
                    result_next.servo_update = 1'b1;
                    result_next.servo_value  = low_value_reg;
                end
            end
        endcase
        result_next.low_threshold  = low_value_next;
        result_next.high_threshold = high_value_next;
        result_next.select_high    = high_sel_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_state_reg <= QUAD_S0;
            low_value_reg  <= 8'd0;
            high_value_reg <= 8'd0;
            high_sel_reg   <= 1'b1;
        end else if (fire) begin
            quad_state_reg <= quad_state_next;
            low_value_reg  <= low_value_next;
            high_value_reg <= high_value_next;
            high_sel_reg   <= high_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== design/quadrature_threshold_adjuster_top.sv =====
// Quadrature threshold adjuster, top level.
// Path from request accept to result valid: input register, then result register.
// Throughput: one request per cycle while m_ready stays high.
// Reset: synchronous active-low aresetn; both valid flags clear, quadrature state 0,
// thresholds 0, high threshold selected.
// Depends on qta_pkg and qta_core.
module quadrature_threshold_adjuster_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qta_pkg::qta_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output qta_pkg::qta_out_t m_payload
);
    import qta_pkg::*;

    // Stage 1: registered request.
    logic    in_valid_reg, in_valid_next;
    qta_in_t in_reg;

    // Stage 2: result valid; payload lives in the core.
    logic    out_valid_reg, out_valid_next;

    logic    advance;   // result register can take a new value
    logic    fire;      // stage 1 request is processed this cycle
    logic    s_take;

    // Result register frees up when empty or being drained this cycle.
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;

    // Input register accepts when empty or when its request moves on now,
    // so requests stream back to back while the result side keeps up.
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (fire)                 in_valid_next = 1'b0;
        if (s_take)               in_valid_next = 1'b1;
        if (m_valid && m_ready)   out_valid_next = 1'b0;
        if (fire)                 out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_payload;
        end
    end

    // State update and result formation happen together when fire is high.
    qta_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (in_reg),
        .result  (m_payload)
    );

    assign m_valid = out_valid_reg;

endmodule
